// ----- src/line_voxel_walk_3d_unit_assert.svh -----
// Assertion macros shared by the voxel line walker RTL.
`ifndef LINE_VOXEL_WALK_3D_UNIT_ASSERT_SVH
`define LINE_VOXEL_WALK_3D_UNIT_ASSERT_SVH

`ifndef SYNTHESIS
// Same-cycle implication, disabled during reset.
`define LVW3_ASSERT_IMP(name, clk, rst, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);
// Next-cycle implication, disabled during reset.
`define LVW3_ASSERT_NEXT(name, clk, rst, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);
`else
`define LVW3_ASSERT_IMP(name, clk, rst, ante, cons, msg)
`define LVW3_ASSERT_NEXT(name, clk, rst, ante, cons, msg)
`endif

`endif

// ----- src/lvw3_pkg.sv -----
// Shared types, constants and helpers of the 3D voxel line walker.
package lvw3_pkg;

  localparam int COORD_BITS_DEF = 10;
  localparam int QUEUE_DEPTH = 2;

  localparam logic KIND_LOAD = 1'b0;
  localparam logic KIND_STEP = 1'b1;

  typedef enum logic [1:0] {
    AXIS_X = 2'd0,
    AXIS_Y = 2'd1,
    AXIS_Z = 2'd2
  } axis_t;

  // Returns the first (idx = 0) or second (idx = 1) minor axis of a major axis.
  function automatic axis_t minor_axis(input axis_t ma, input logic idx);
    axis_t res;
    case (ma)
      AXIS_X: res = idx ? AXIS_Z : AXIS_Y;
      AXIS_Y: res = idx ? AXIS_Z : AXIS_X;
      AXIS_Z: res = idx ? AXIS_Y : AXIS_X;
      default: res = idx ? AXIS_Z : AXIS_Y;
    endcase
    return res;
  endfunction

endpackage

// ----- src/lvw3_front.sv -----
// Front end: decodes an input item and precomputes the line setup for loads.
module lvw3_front #(
  parameter int COORD_BITS = lvw3_pkg::COORD_BITS_DEF,
  parameter type cmd_t = logic
) (
  input  logic                  kind,
  input  logic [COORD_BITS-1:0] start_x,
  input  logic [COORD_BITS-1:0] start_y,
  input  logic [COORD_BITS-1:0] start_z,
  input  logic [COORD_BITS-1:0] end_x,
  input  logic [COORD_BITS-1:0] end_y,
  input  logic [COORD_BITS-1:0] end_z,
  output cmd_t                  cmd
);

  logic [2:0][COORD_BITS-1:0] s_coord;
  logic [2:0][COORD_BITS-1:0] e_coord;
  logic [2:0][COORD_BITS-1:0] dabs;
  logic [2:0]                 signs;
  lvw3_pkg::axis_t            major;
  lvw3_pkg::axis_t            mi;
  logic [COORD_BITS-1:0]      dmaj;
  logic [COORD_BITS-1:0]      target;

  always_comb begin
    s_coord = {start_z, start_y, start_x};
    e_coord = {end_z, end_y, end_x};
    for (int k = 0; k < 3; k++) begin
      if (e_coord[k] > s_coord[k]) begin
        dabs[k]  = e_coord[k] - s_coord[k];
        signs[k] = 1'b0;
      end else begin
        dabs[k]  = s_coord[k] - e_coord[k];
        signs[k] = 1'b1;
      end
    end

    // Largest delta wins; ties go to x first, then y.
    if (dabs[0] >= dabs[1] && dabs[0] >= dabs[2]) begin
      major = lvw3_pkg::AXIS_X;
    end else if (dabs[1] >= dabs[0] && dabs[1] >= dabs[2]) begin
      major = lvw3_pkg::AXIS_Y;
    end else begin
      major = lvw3_pkg::AXIS_Z;
    end

    case (major)
      lvw3_pkg::AXIS_X: begin
        dmaj   = dabs[0];
        target = e_coord[0];
      end
      lvw3_pkg::AXIS_Y: begin
        dmaj   = dabs[1];
        target = e_coord[1];
      end
      lvw3_pkg::AXIS_Z: begin
        dmaj   = dabs[2];
        target = e_coord[2];
      end
      default: begin
        dmaj   = dabs[0];
        target = e_coord[0];
      end
    endcase

    cmd.kind   = kind;
    cmd.start  = s_coord;
    cmd.target = target;
    cmd.dabs   = dabs;
    cmd.signs  = signs;
    cmd.major  = major;
    mi = lvw3_pkg::AXIS_X;
    for (int k = 0; k < 2; k++) begin
      mi = lvw3_pkg::minor_axis(major, k[0]);
      cmd.err[k] = {2'b00, dabs[mi], 1'b0} - {3'b000, dmaj};
    end
  end

endmodule

// ----- src/lvw3_queue.sv -----
// Short command queue between the front end and the walker back end.
module lvw3_queue #(
  parameter type cmd_t = logic
) (
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  cmd_t push_cmd,
  output logic full,
  input  logic pop,
  output logic head_valid,
  output cmd_t head_cmd
);

  localparam int DEPTH = lvw3_pkg::QUEUE_DEPTH;
  localparam int PTR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_BITS = $clog2(DEPTH + 1);
  localparam logic [PTR_BITS-1:0] LAST_PTR = PTR_BITS'(DEPTH - 1);
  localparam logic [CNT_BITS-1:0] FULL_CNT = CNT_BITS'(DEPTH);

  cmd_t                entries [DEPTH];
  logic [PTR_BITS-1:0] wr_ptr;
  logic [PTR_BITS-1:0] rd_ptr;
  logic [CNT_BITS-1:0] count;

  assign full       = (count == FULL_CNT);
  assign head_valid = (count != '0);
  assign head_cmd   = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == LAST_PTR) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == LAST_PTR) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

// ----- src/lvw3_back.sv -----
// Back end: holds the walk state, steps one voxel per command and registers the result.
module lvw3_back #(
  parameter int COORD_BITS = lvw3_pkg::COORD_BITS_DEF,
  parameter type cmd_t = logic
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  head_valid,
  input  cmd_t                  head_cmd,
  output logic                  pop,
  output logic                  voxel_valid,
  input  logic                  voxel_stall,
  output logic [COORD_BITS-1:0] voxel_x,
  output logic [COORD_BITS-1:0] voxel_y,
  output logic [COORD_BITS-1:0] voxel_z,
  output logic                  valid_res,
  output logic                  last
);

  localparam int EW = COORD_BITS + 3;

  // Walk state.
  logic [2:0][COORD_BITS-1:0] cur;
  logic [COORD_BITS-1:0]      target;
  logic [2:0][COORD_BITS-1:0] dabs;
  logic [2:0]                 signs;
  logic [1:0][EW-1:0]         err;
  lvw3_pkg::axis_t            major;
  logic                       active;

  logic [2:0][COORD_BITS-1:0] cur_next;
  logic [1:0][EW-1:0]         err_next;
  lvw3_pkg::axis_t            mi;
  logic [EW-1:0]              two_dmaj;
  logic [EW-1:0]              two_dmin;
  logic                       step_last;
  logic                       load_zero;

  function automatic logic [COORD_BITS-1:0] move_one(
    input logic [COORD_BITS-1:0] c,
    input logic                  down
  );
    return down ? c - 1'b1 : c + 1'b1;
  endfunction

  // A new command enters whenever the output register is empty or being drained.
  assign pop = head_valid && (!voxel_valid || !voxel_stall);

  always_comb begin
    cur_next = cur;
    err_next = err;
    mi       = lvw3_pkg::AXIS_X;
    two_dmin = '0;
    two_dmaj = {2'b00, dabs[major], 1'b0};
    cur_next[major] = move_one(cur[major], signs[major]);
    for (int k = 0; k < 2; k++) begin
      mi       = lvw3_pkg::minor_axis(major, k[0]);
      two_dmin = {2'b00, dabs[mi], 1'b0};
      if (!err[k][EW-1]) begin
        cur_next[mi] = move_one(cur[mi], signs[mi]);
        err_next[k]  = err[k] - two_dmaj + two_dmin;
      end else begin
        err_next[k]  = err[k] + two_dmin;
      end
    end
    step_last = (cur_next[major] == target);
    load_zero = (head_cmd.dabs[head_cmd.major] == '0);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      active      <= 1'b0;
      voxel_valid <= 1'b0;
    end else begin
      if (pop) begin
        voxel_valid <= 1'b1;
        if (head_cmd.kind == lvw3_pkg::KIND_LOAD) begin
          cur       <= head_cmd.start;
          target    <= head_cmd.target;
          dabs      <= head_cmd.dabs;
          signs     <= head_cmd.signs;
          err       <= head_cmd.err;
          major     <= head_cmd.major;
          active    <= !load_zero;
          voxel_x   <= head_cmd.start[0];
          voxel_y   <= head_cmd.start[1];
          voxel_z   <= head_cmd.start[2];
          valid_res <= 1'b1;
          last      <= load_zero;
        end else if (active) begin
          cur       <= cur_next;
          err       <= err_next;
          active    <= !step_last;
          voxel_x   <= cur_next[0];
          voxel_y   <= cur_next[1];
          voxel_z   <= cur_next[2];
          valid_res <= 1'b1;
          last      <= step_last;
        end else begin
          voxel_x   <= '0;
          voxel_y   <= '0;
          voxel_z   <= '0;
          valid_res <= 1'b0;
          last      <= 1'b0;
        end
      end else if (!voxel_stall) begin
        voxel_valid <= 1'b0;
      end
    end
  end

endmodule

// ----- src/line_voxel_walk_3d_unit.sv -----
// Top level of the 3D Bresenham voxel line walker.
// The walker takes one item per cycle while item_stall is low and returns one
// result per item. A load item (kind = 0) latches start and end voxels, picks
// the major axis (largest absolute delta, ties to x, then y) and returns the
// start voxel; a step item (kind = 1) moves one voxel along the line and
// returns it, with last set at the end point. A step while no walk is in
// progress returns valid_res = 0 and zero coordinates. The front end computes
// the load setup, a two-entry command queue decouples it from the back end, and
// the back end computes the next error terms combinationally, so with no output
// stall the sustained rate is one item per clock. Each item is registered in the
// queue and its result then in the output register; the input stalls only when
// the queue is full.
`include "line_voxel_walk_3d_unit_assert.svh"

module line_voxel_walk_3d_unit #(
  parameter int COORD_BITS = lvw3_pkg::COORD_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  item_valid,
  output logic                  item_stall,
  input  logic                  kind,
  input  logic [COORD_BITS-1:0] start_x,
  input  logic [COORD_BITS-1:0] start_y,
  input  logic [COORD_BITS-1:0] start_z,
  input  logic [COORD_BITS-1:0] end_x,
  input  logic [COORD_BITS-1:0] end_y,
  input  logic [COORD_BITS-1:0] end_z,
  output logic                  voxel_valid,
  input  logic                  voxel_stall,
  output logic [COORD_BITS-1:0] voxel_x,
  output logic [COORD_BITS-1:0] voxel_y,
  output logic [COORD_BITS-1:0] voxel_z,
  output logic                  valid_res,
  output logic                  last
);

  localparam int EW = COORD_BITS + 3;

  typedef struct packed {
    logic                       kind;
    logic [2:0][COORD_BITS-1:0] start;
    logic [COORD_BITS-1:0]      target;
    logic [2:0][COORD_BITS-1:0] dabs;
    logic [2:0]                 signs;
    logic [1:0][EW-1:0]         err;
    lvw3_pkg::axis_t            major;
  } cmd_t;

  cmd_t front_cmd;
  cmd_t head_cmd;
  logic q_full;
  logic q_push;
  logic q_pop;
  logic head_valid;
  logic idle_clean;

  assign item_stall = q_full;
  assign q_push     = item_valid && !q_full;

  lvw3_front #(
    .COORD_BITS(COORD_BITS),
    .cmd_t     (cmd_t)
  ) u_front (
    .kind   (kind),
    .start_x(start_x),
    .start_y(start_y),
    .start_z(start_z),
    .end_x  (end_x),
    .end_y  (end_y),
    .end_z  (end_z),
    .cmd    (front_cmd)
  );

  lvw3_queue #(
    .cmd_t(cmd_t)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_cmd  (front_cmd),
    .full      (q_full),
    .pop       (q_pop),
    .head_valid(head_valid),
    .head_cmd  (head_cmd)
  );

  lvw3_back #(
    .COORD_BITS(COORD_BITS),
    .cmd_t     (cmd_t)
  ) u_back (
    .clk        (clk),
    .rst        (rst),
    .head_valid (head_valid),
    .head_cmd   (head_cmd),
    .pop        (q_pop),
    .voxel_valid(voxel_valid),
    .voxel_stall(voxel_stall),
    .voxel_x    (voxel_x),
    .voxel_y    (voxel_y),
    .voxel_z    (voxel_z),
    .valid_res  (valid_res),
    .last       (last)
  );

  assign idle_clean = !last && voxel_x == '0 && voxel_y == '0 && voxel_z == '0;

  // The back end only takes a command that the queue actually holds.
  `LVW3_ASSERT_IMP(a_pop_nonempty, clk, rst, q_pop, head_valid, "pop from empty queue")
  // Every command taken by the back end shows up in the output register next cycle.
  `LVW3_ASSERT_NEXT(a_pop_result, clk, rst, q_pop, voxel_valid, "command lost after pop")
  // An idle step result carries no end flag and zero coordinates.
  `LVW3_ASSERT_IMP(a_idle_result, clk, rst, voxel_valid && !valid_res, idle_clean, "idle step result not cleared")

endmodule
